[sv/va_pkg.sv]
// Shared widths, action codes and controller command types for the voice allocator.
`default_nettype none

package va_pkg;

   localparam int NUM_VOICES_DEF = 16;

   localparam int KEY_W   = 32;
   localparam int PITCH_W = 7;
   localparam int VEL_W   = 16;
   localparam int TIME_W  = 48;
   localparam int SLOT_W  = 4;
   localparam int ACT_W   = 3;

   // A host key of all ones asks for the pitch to be used as the key.
   localparam logic [KEY_W-1:0] KEY_WILD = {KEY_W{1'b1}};

   typedef enum logic [ACT_W-1:0] {
      ACT_NEW       = 3'd0,
      ACT_RETRIGGER = 3'd1,
      ACT_STOLEN    = 3'd2,
      ACT_RELEASED  = 3'd3,
      ACT_NOT_FOUND = 3'd4,
      ACT_REFUSED   = 3'd5
   } action_type;

   typedef enum logic {
      MODE_ON  = 1'b0,
      MODE_OFF = 1'b1
   } mode_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic last_addr;
      logic out_free;
   } status_type;

endpackage : va_pkg

`default_nettype wire

[sv/va_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module va_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : va_ram

`default_nettype wire

[sv/va_ctrl.sv]
// Controller state machine that sequences accept, slot scan, drain and commit.
`default_nettype none

module va_ctrl
   import va_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (status.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last slot read returns this cycle and is compared.
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : va_ctrl

`default_nettype wire

[sv/va_dpath.sv]
// Datapath: request latch, slot store, scan trackers, decision and result register.
`default_nettype none

module va_dpath
   import va_pkg::*;
#(
   parameter int NUM_VOICES = NUM_VOICES_DEF,
   localparam int IDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   output status_type                     status,
   input  wire logic                      req_mode,
   input  wire logic signed [KEY_W-1:0]   req_note_key,
   input  wire logic [PITCH_W-1:0]        req_pitch,
   input  wire logic [VEL_W-1:0]          req_velocity,
   input  wire logic [TIME_W-1:0]         req_start_time,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [SLOT_W-1:0]              rsp_slot,
   output logic [ACT_W-1:0]               rsp_action,
   output logic signed [KEY_W-1:0]        rsp_resolved_key,
   output logic [PITCH_W-1:0]             rsp_pitch_out,
   output logic [VEL_W-1:0]               rsp_velocity_out
);

   localparam int ENT_W = KEY_W + TIME_W;

   // Latched request.
   logic               mode_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [PITCH_W-1:0] pitch_ff;
   logic [VEL_W-1:0]   vel_ff;
   logic [TIME_W-1:0]  now_ff;

   // Scan address and compare stage.
   logic [IDX_W-1:0]   addr_ff;
   logic               cmp_vld_ff;
   logic [IDX_W-1:0]   cmp_idx_ff;

   // Trackers for the first key match, first free slot and oldest slot.
   logic               hit_vld_ff,  free_vld_ff,  old_vld_ff;
   logic [IDX_W-1:0]   hit_idx_ff,  free_idx_ff,  old_idx_ff;
   logic [TIME_W-1:0]  least_ff;

   logic [NUM_VOICES-1:0] used_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   action_type         rsp_action_ff;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [PITCH_W-1:0] rsp_pitch_ff;
   logic [VEL_W-1:0]   rsp_vel_ff;

   logic [ENT_W-1:0]   rd_data;
   logic [KEY_W-1:0]   rd_key;
   logic [TIME_W-1:0]  rd_start;
   logic               cur_used;

   action_type         act;
   logic [IDX_W-1:0]   sel_idx;
   logic               sel_vld;
   logic               wr_en;
   logic [IDX_W+SLOT_W-1:0] slot_ext;

   va_ram #(
      .WIDTH(ENT_W),
      .DEPTH(NUM_VOICES)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(sel_idx),
      .wr_data({key_ff, now_ff}),
      .rd_en  (cmd.issue),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   assign rd_key   = rd_data[ENT_W-1:TIME_W];
   assign rd_start = rd_data[TIME_W-1:0];
   assign cur_used = used_ff[cmp_idx_ff];

   assign status = '{last_addr: (addr_ff == IDX_W'(NUM_VOICES - 1)),
                     out_free:  (!rsp_valid_ff || rsp_ready)};

   // Decision once the scan is complete.
   always_comb begin
      act     = ACT_REFUSED;
      sel_idx = '0;
      sel_vld = 1'b0;
      if (mode_ff == MODE_OFF) begin
         if (hit_vld_ff) begin
            act     = ACT_RELEASED;
            sel_idx = hit_idx_ff;
            sel_vld = 1'b1;
         end else begin
            act = ACT_NOT_FOUND;
         end
      end else if (hit_vld_ff) begin
         act     = ACT_RETRIGGER;
         sel_idx = hit_idx_ff;
         sel_vld = 1'b1;
      end else if (free_vld_ff) begin
         act     = ACT_NEW;
         sel_idx = free_idx_ff;
         sel_vld = 1'b1;
      end else if (old_vld_ff) begin
         act     = ACT_STOLEN;
         sel_idx = old_idx_ff;
         sel_vld = 1'b1;
      end
   end

   assign wr_en    = cmd.commit && sel_vld && (mode_ff == MODE_ON);
   assign slot_ext = {{SLOT_W{1'b0}}, sel_idx};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff  <= req_mode;
         pitch_ff <= req_pitch;
         vel_ff   <= req_velocity;
         now_ff   <= req_start_time;
         if (KEY_W'(req_note_key) == KEY_WILD) begin
            key_ff <= KEY_W'(req_pitch);
         end else begin
            key_ff <= KEY_W'(req_note_key);
         end
      end
      if (cmd.start) begin
         least_ff <= req_start_time;
      end else if (cmp_vld_ff && cur_used && (rd_start < least_ff)) begin
         least_ff <= rd_start;
      end
      if (cmd.issue) begin
         cmp_idx_ff <= addr_ff;
      end
      if (cmp_vld_ff) begin
         if (cur_used && (rd_key == key_ff) && !hit_vld_ff) begin
            hit_idx_ff <= cmp_idx_ff;
         end
         if (!cur_used && !free_vld_ff) begin
            free_idx_ff <= cmp_idx_ff;
         end
         if (cur_used && (rd_start < least_ff)) begin
            old_idx_ff <= cmp_idx_ff;
         end
      end
      if (cmd.commit) begin
         rsp_slot_ff   <= sel_vld ? slot_ext[SLOT_W-1:0] : '0;
         rsp_action_ff <= act;
         rsp_key_ff    <= key_ff;
         rsp_pitch_ff  <= pitch_ff;
         rsp_vel_ff    <= wr_en ? vel_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         hit_vld_ff   <= 1'b0;
         free_vld_ff  <= 1'b0;
         old_vld_ff   <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cmp_vld_ff <= cmd.issue;
         if (cmd.start) begin
            addr_ff     <= '0;
            hit_vld_ff  <= 1'b0;
            free_vld_ff <= 1'b0;
            old_vld_ff  <= 1'b0;
         end else begin
            if (cmd.issue) begin
               addr_ff <= addr_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               if (cur_used && (rd_key == key_ff)) begin
                  hit_vld_ff <= 1'b1;
               end
               if (!cur_used) begin
                  free_vld_ff <= 1'b1;
               end
               if (cur_used && (rd_start < least_ff)) begin
                  old_vld_ff <= 1'b1;
               end
            end
         end
         if (wr_en && (act == ACT_NEW)) begin
            used_ff[sel_idx] <= 1'b1;
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_resolved_key = signed'(rsp_key_ff);
   assign rsp_pitch_out    = rsp_pitch_ff;
   assign rsp_velocity_out = rsp_vel_ff;

   // A result must never overwrite one that is still waiting to be taken.
   a_commit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while stalled");

   // A newly allocated slot is marked in use from the next cycle on.
   a_new_marks_used : assert property (@(posedge clock) disable iff (reset)
      (wr_en && (act == ACT_NEW)) |=> used_ff[$past(sel_idx)])
      else $error("new slot not marked in use");

   // Refused and not-found transactions carry slot zero and no velocity.
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_action_ff == ACT_REFUSED) ||
                        (rsp_action_ff == ACT_NOT_FOUND)))
      |-> ((rsp_slot_ff == '0) && (rsp_vel_ff == '0)))
      else $error("miss result with nonzero slot or velocity");

   // A note-off never changes the occupancy of the slots.
   a_off_keeps_used : assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && (mode_ff == MODE_OFF)) |=> (used_ff == $past(used_ff)))
      else $error("note-off changed slot occupancy");

endmodule : va_dpath

`default_nettype wire

[sv/voice_allocator_oldest_steal.sv]
// Top level of the polyphonic voice allocator with oldest-note stealing.
`default_nettype none

// Each transaction (note-on or note-off) is accepted when the block is idle; the request
// is latched, every slot of the slot RAM is read in turn through its single read port, the
// last slot is compared and the decision is committed. The scan finds the first slot
// holding the key, the first free slot and the oldest slot started strictly before the
// note's time; a present key is retriggered, otherwise a free slot is taken, otherwise the
// oldest is stolen, and with none of these the note-on is refused. A note-off reports the
// slot holding its key as released, or not found. Results sit in an output register, so
// the next request is accepted while a result waits; a commit waits only if the previous
// result has still not been taken. No clearing pass is needed after reset: occupancy
// lives in flip-flops and only the contents of occupied slots are used from the RAM.
module voice_allocator_oldest_steal
   import va_pkg::*;
#(
   parameter int NUM_VOICES = NUM_VOICES_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_mode,
   input  wire logic signed [KEY_W-1:0]   req_note_key,
   input  wire logic [PITCH_W-1:0]        req_pitch,
   input  wire logic [VEL_W-1:0]          req_velocity,
   input  wire logic [TIME_W-1:0]         req_start_time,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [SLOT_W-1:0]              rsp_slot,
   output logic [ACT_W-1:0]               rsp_action,
   output logic signed [KEY_W-1:0]        rsp_resolved_key,
   output logic [PITCH_W-1:0]             rsp_pitch_out,
   output logic [VEL_W-1:0]               rsp_velocity_out
);

   cmd_type    cmd;
   status_type status;

   va_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   va_dpath #(
      .NUM_VOICES(NUM_VOICES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_mode),
      .req_note_key    (req_note_key),
      .req_pitch       (req_pitch),
      .req_velocity    (req_velocity),
      .req_start_time  (req_start_time),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot        (rsp_slot),
      .rsp_action      (rsp_action),
      .rsp_resolved_key(rsp_resolved_key),
      .rsp_pitch_out   (rsp_pitch_out),
      .rsp_velocity_out(rsp_velocity_out)
   );

endmodule : voice_allocator_oldest_steal

`default_nettype wire

[sim/tb_voice_allocator_oldest_steal.sv]
// Self-checking testbench for the voice allocator with oldest-note stealing.
`timescale 1ns / 100ps

module tb_voice_allocator_oldest_steal;
   import va_pkg::*;

   localparam int VOICES      = NUM_VOICES_DEF;
   localparam int LATENCY     = VOICES + 3;
   localparam int STALL_LIMIT = 4000;
   localparam int KEY_POOL    = 20;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot;
      action_type         action;
      logic [KEY_W-1:0]   key;
      logic [PITCH_W-1:0] pitch;
      logic [VEL_W-1:0]   vel;
   } voice_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic                      req_mode;
   logic signed [KEY_W-1:0]   req_note_key;
   logic [PITCH_W-1:0]        req_pitch;
   logic [VEL_W-1:0]          req_velocity;
   logic [TIME_W-1:0]         req_start_time;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [SLOT_W-1:0]         rsp_slot;
   logic [ACT_W-1:0]          rsp_action;
   logic signed [KEY_W-1:0]   rsp_resolved_key;
   logic [PITCH_W-1:0]        rsp_pitch_out;
   logic [VEL_W-1:0]          rsp_velocity_out;

   // Shadow copy of the voice table.
   logic                voice_busy [VOICES];
   logic [KEY_W-1:0]    voice_key [VOICES];
   logic [TIME_W-1:0]   voice_start [VOICES];

   voice_result_type    awaited_results [$];
   logic [KEY_W-1:0]    key_pool [KEY_POOL];
   logic [TIME_W-1:0]   now_ticks;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_cycles;
   int mismatches;
   int notes_sent;
   int action_seen [6];

   voice_allocator_oldest_steal #(.NUM_VOICES(VOICES)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_note_key     (req_note_key),
      .req_pitch        (req_pitch),
      .req_velocity     (req_velocity),
      .req_start_time   (req_start_time),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slot         (rsp_slot),
      .rsp_action       (rsp_action),
      .rsp_resolved_key (rsp_resolved_key),
      .rsp_pitch_out    (rsp_pitch_out),
      .rsp_velocity_out (rsp_velocity_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the result of one note event and updates the shadow table.
   function automatic voice_result_type allocate_voice(input logic mode,
                                                       input logic [KEY_W-1:0] key_in,
                                                       input logic [PITCH_W-1:0] pitch,
                                                       input logic [VEL_W-1:0] vel,
                                                       input logic [TIME_W-1:0] now);
      voice_result_type r;
      logic [KEY_W-1:0] k;
      logic [TIME_W-1:0] least;
      int hit;
      int free_slot;
      int oldest;
      int s;
      r = '0;
      k = (key_in == KEY_WILD) ? KEY_W'(pitch) : key_in;
      hit = -1;
      free_slot = -1;
      oldest = -1;
      s = -1;
      least = now;
      for (int i = 0; i < VOICES; i++) begin
         if (hit < 0 && voice_busy[i] && voice_key[i] == k) hit = i;
         if (free_slot < 0 && !voice_busy[i]) free_slot = i;
         // Strictly older only, so the first of several equal start times wins.
         if (voice_busy[i] && voice_start[i] < least) begin
            least = voice_start[i];
            oldest = i;
         end
      end
      r.key = k;
      r.pitch = pitch;
      if (mode == MODE_ON) begin
         if (hit >= 0) begin
            s = hit;
            r.action = ACT_RETRIGGER;
         end else if (free_slot >= 0) begin
            s = free_slot;
            r.action = ACT_NEW;
            voice_busy[s] = 1'b1;
         end else if (oldest >= 0) begin
            s = oldest;
            r.action = ACT_STOLEN;
         end else begin
            r.action = ACT_REFUSED;
         end
         if (s >= 0) begin
            voice_key[s] = k;
            voice_start[s] = now;
            r.vel = vel;
         end
      end else begin
         s = hit;
         r.action = (hit >= 0) ? ACT_RELEASED : ACT_NOT_FOUND;
      end
      if (s >= 0) r.slot = SLOT_W'(s);
      return r;
   endfunction

   // Offers one note event and records its expected result once accepted.
   task automatic send_note(input logic mode, input logic [KEY_W-1:0] key,
                            input logic [PITCH_W-1:0] pitch, input logic [VEL_W-1:0] vel,
                            input logic [TIME_W-1:0] start);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_note_key   <= key;
      req_pitch      <= pitch;
      req_velocity   <= vel;
      req_start_time <= start;
      do @(posedge clock); while (!req_ready);
      awaited_results.push_back(allocate_voice(mode, key, pitch, vel, start));
      notes_sent++;
   endtask

   // The sender stops offering while it waits, so nothing is accepted twice.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_note(MODE_ON, 32'd100, 7'd60, 16'h0000, 48'd1000);
      send_note(MODE_ON, KEY_WILD, 7'd127, 16'hFFFF, 48'd1000);
      send_note(MODE_ON, 32'd100, 7'd61, 16'h1234, 48'd2000);
      send_note(MODE_OFF, KEY_WILD, 7'd127, 16'hABCD, 48'd2100);
      send_note(MODE_OFF, 32'd555, 7'd5, 16'h8000, 48'd2200);
      send_note(MODE_ON, KEY_WILD, 7'd0, 16'h0001, 48'd1000);
      // Fill the rest of the table, all with the same start time.
      for (int i = 3; i < VOICES; i++) begin
         if (i == 3) send_note(MODE_ON, 32'h7FFF_FFFF, 7'd10, 16'h00FF, 48'd1000);
         else if (i == 4) send_note(MODE_ON, 32'h8000_0000, 7'd11, 16'hFF00, 48'd1000);
         else send_note(MODE_ON, 32'd300 + i, 7'(i), 16'(i * 4099), 48'd1000);
      end
      // Nothing started strictly before time zero or before an equal time.
      send_note(MODE_ON, 32'd999, 7'd20, 16'h5555, 48'd0);
      send_note(MODE_ON, 32'd998, 7'd21, 16'hAAAA, 48'd1000);
      send_note(MODE_ON, 32'd997, 7'd22, 16'h7FFF, {TIME_W{1'b1}});
      send_note(MODE_ON, 32'd996, 7'd23, 16'hFFFE, {TIME_W{1'b1}});
      send_note(MODE_OFF, 32'h7FFF_FFFF, 7'd0, 16'hFFFF, 48'd3000);
      send_note(MODE_ON, 32'd100, 7'd62, 16'h4321, 48'd0);
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int count);
      logic m;
      logic [KEY_W-1:0] k;
      logic [PITCH_W-1:0] p;
      logic [TIME_W-1:0] t;
      for (int n = 0; n < count; n++) begin
         p = PITCH_W'($urandom_range(127));
         if ($urandom_range(99) < 10) begin
            m = 1'($urandom_range(1));
            k = $urandom;
            t = TIME_W'({$urandom, $urandom});
         end else begin
            m = ($urandom_range(99) < 60) ? MODE_ON : MODE_OFF;
            if ($urandom_range(3) == 0) begin
               k = KEY_WILD;
               p = PITCH_W'($urandom_range(40, 51));
            end else begin
               k = key_pool[$urandom_range(KEY_POOL - 1)];
            end
            case ($urandom_range(39))
               0: begin
                  now_ticks = TIME_W'({$urandom, $urandom});
                  t = now_ticks;
               end
               1, 2: t = now_ticks - TIME_W'($urandom_range(3000));
               default: begin
                  now_ticks = now_ticks + TIME_W'($urandom_range(50));
                  t = now_ticks;
               end
            endcase
         end
         send_note(m, k, p, VEL_W'($urandom), t);
      end
      wait_for_results();
   endtask

   // The receiver is held off while the sender keeps offering, so the block backs up.
   task automatic test_backpressure();
      hold_cycles = 400;
      for (int n = 0; n < 30; n++) begin
         now_ticks = now_ticks + TIME_W'($urandom_range(1, 20));
         send_note(MODE_ON, key_pool[$urandom_range(KEY_POOL - 1)],
                   PITCH_W'($urandom_range(127)), VEL_W'($urandom), now_ticks);
      end
      wait_for_results();
   endtask

   // Receiver readiness, with long hold-offs counted here.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Compares each result transaction with the oldest expectation.
   initial begin
      voice_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result: slot %0d action %0d", rsp_slot, rsp_action);
               mismatches++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_slot);
                  mismatches++;
               end
               if (rsp_action !== want.action) begin
                  $error("action: expected %0d, got %0d", want.action, rsp_action);
                  mismatches++;
               end
               if (rsp_resolved_key !== want.key) begin
                  $error("resolved_key: expected %h, got %h", want.key, rsp_resolved_key);
                  mismatches++;
               end
               if (rsp_pitch_out !== want.pitch) begin
                  $error("pitch_out: expected %0d, got %0d", want.pitch, rsp_pitch_out);
                  mismatches++;
               end
               if (rsp_velocity_out !== want.vel) begin
                  $error("velocity_out: expected %h, got %h", want.vel, rsp_velocity_out);
                  mismatches++;
               end
               if (want.action <= ACT_REFUSED) action_seen[want.action]++;
            end
         end
      end
   end

   // Ends the run if no transaction moves on either channel for too long.
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("tb_voice_allocator_oldest_steal failed");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_ON;
      req_note_key   = '0;
      req_pitch      = '0;
      req_velocity   = '0;
      req_start_time = '0;
      hold_cycles    = 0;
      mismatches     = 0;
      notes_sent     = 0;
      now_ticks      = TIME_W'(5000);
      send_idle_pct  = 12;
      recv_idle_pct  = 80;
      foreach (action_seen[i]) action_seen[i] = 0;
      for (int i = 0; i < VOICES; i++) begin
         voice_busy[i]  = 1'b0;
         voice_key[i]   = '0;
         voice_start[i] = '0;
      end
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h7FFF_FFFF;
      key_pool[1] = 32'h8000_0000;
      key_pool[2] = 32'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_traffic(600);
      send_idle_pct = 80;
      recv_idle_pct = 12;
      test_random_traffic(600);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_traffic(600);

      wait_for_results();
      repeat (2 * LATENCY) @(posedge clock);
      $display("Sent %0d note events through all idling phases and a long receiver hold-off.",
               notes_sent);
      $display("Results: %0d new, %0d retrigger, %0d stolen, %0d released,",
               action_seen[ACT_NEW], action_seen[ACT_RETRIGGER], action_seen[ACT_STOLEN],
               action_seen[ACT_RELEASED]);
      $display("         %0d not found, %0d refused",
               action_seen[ACT_NOT_FOUND], action_seen[ACT_REFUSED]);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("tb_voice_allocator_oldest_steal passed");
      end else begin
         $display("tb_voice_allocator_oldest_steal failed");
      end
      $finish;
   end

endmodule

[files.f]
sv/va_pkg.sv
sv/va_ram.sv
sv/va_ctrl.sv
sv/va_dpath.sv
sv/voice_allocator_oldest_steal.sv
sim/tb_voice_allocator_oldest_steal.sv
